// ===== hdl/dqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dqs_pkg;

   localparam int LANES      = 8;
   localparam int FP6_W      = 6;
   localparam int GROUP_W    = LANES * FP6_W;
   localparam int FP16_W     = 16;
   localparam int NSTAGES    = 4;

   localparam logic [15:0] QNAN_BITS = 16'h7FFF;
   localparam logic [14:0] INF_BITS  = 15'h7C00;

   typedef struct packed {
      logic [NSTAGES-1:0] en;
   } pipe_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/dqs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dqs_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output dqs_pkg::pipe_ctrl_type ctrl
);
   import dqs_pkg::*;

   logic [NSTAGES-1:0] valid_ff;
   logic [NSTAGES-1:0] valid_in;
   logic [NSTAGES-1:0] en;

   // a stage moves on when empty or when the next one moves on
   always_comb begin
      en[NSTAGES-1] = !valid_ff[NSTAGES-1] || !rsp_stall;
      for (int k = NSTAGES-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en   = en;
   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NSTAGES-1];

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff && rsp_stall))
      else $error("input stalled with a bubble in the pipe");
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted beat not in first stage");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result beat dropped");

endmodule
`default_nettype wire

// ===== hdl/dqs_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dqs_lane (
   input  wire                    clock,
   input  wire dqs_pkg::pipe_ctrl_type ctrl,
   input  wire  [5:0]             v6,
   input  wire  [15:0]            scale,
   output logic [15:0]            result
);
   import dqs_pkg::*;

   // stage 1: decode
   logic [2:0]  sig_a_ff, sig_a_in;
   logic [2:0]  ea_ff, ea_in;
   logic [10:0] sig_b_ff, sig_b_in;
   logic [4:0]  eb_ff, eb_in;
   logic        sign1_ff, sign1_in;
   logic        spec1_ff, spec1_in;
   logic [15:0] sval1_ff, sval1_in;

   always_comb begin
      sig_a_in = (v6[4:2] != 3'd0) ? {1'b1, v6[1:0]} : {1'b0, v6[1:0]};
      ea_in    = (v6[4:2] != 3'd0) ? v6[4:2] : 3'd1;
      sig_b_in = (scale[14:10] != 5'd0) ? {1'b1, scale[9:0]} : {1'b0, scale[9:0]};
      eb_in    = (scale[14:10] != 5'd0) ? scale[14:10] : 5'd1;
      sign1_in = v6[5] ^ scale[15];
      spec1_in = (scale[14:10] == 5'd31);
      // inf scale times zero, or NaN scale
      sval1_in = ((scale[9:0] != 10'd0) || (sig_a_in == 3'd0)) ? QNAN_BITS
                                                             : {sign1_in, INF_BITS};
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         sig_a_ff <= sig_a_in;
         ea_ff    <= ea_in;
         sig_b_ff <= sig_b_in;
         eb_ff    <= eb_in;
         sign1_ff <= sign1_in;
         spec1_ff <= spec1_in;
         sval1_ff <= sval1_in;
      end
   end

   // stage 2: product and exponent sum
   logic [13:0] p2_ff, p2_in;
   logic [5:0]  s2_ff, s2_in;
   logic        sign2_ff, spec2_ff;
   logic [15:0] sval2_ff;

   assign p2_in = 14'({3'd0, sig_b_ff} * {11'd0, sig_a_ff});
   assign s2_in = {3'd0, ea_ff} + {1'b0, eb_ff};

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         p2_ff    <= p2_in;
         s2_ff    <= s2_in;
         sign2_ff <= sign1_ff;
         spec2_ff <= spec1_ff;
         sval2_ff <= sval1_ff;
      end
   end

   // stage 3: leading one, exponent and shift
   logic [3:0]        msb;
   logic [6:0]        tsum;
   logic [5:0]        bexp3_ff, bexp3_in;
   logic signed [6:0] sh3_ff, sh3_in;
   logic [13:0]       p3_ff;
   logic              sign3_ff, spec3_ff, zero3_ff;
   logic [15:0]       sval3_ff;

   always_comb begin
      msb = 4'd0;
      for (int i = 0; i < 14; i++) begin
         if (p2_ff[i]) msb = 4'(i);
      end
      tsum = {3'd0, msb} + {1'b0, s2_ff};
      bexp3_in = (tsum < 7'd16) ? 6'd0 : 6'(tsum - 7'd16);
      sh3_in = $signed({1'b0, bexp3_in}) - $signed({1'b0, s2_ff}) + 7'sd6;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         bexp3_ff <= bexp3_in;
         sh3_ff   <= sh3_in;
         p3_ff    <= p2_ff;
         sign3_ff <= sign2_ff;
         spec3_ff <= spec2_ff;
         zero3_ff <= (p2_ff == 14'd0);
         sval3_ff <= sval2_ff;
      end
   end

   // stage 4: align, round to nearest even, pack
   logic [23:0] lsh;
   logic [2:0]  rsh;
   logic [13:0] rem, half, mask;
   logic [13:0] rmant;
   logic [11:0] mant;
   logic [16:0] bits;
   logic [15:0] res_ff, res_in;

   always_comb begin
      lsh   = {10'd0, p3_ff} << 4'(-sh3_ff);
      rsh   = 3'(sh3_ff);
      mask  = (14'd1 << rsh) - 14'd1;
      half  = (14'd1 << rsh) >> 1;
      rem   = p3_ff & mask;
      rmant = p3_ff >> rsh;
      if (sh3_ff <= 7'sd0) begin
         mant = lsh[11:0];
      end else if ((rem > half) || ((rem == half) && rmant[0])) begin
         mant = rmant[11:0] + 12'd1;
      end else begin
         mant = rmant[11:0];
      end
      bits = {1'b0, bexp3_ff, 10'd0} + {5'd0, mant};
      if (bits >= {2'b0, INF_BITS}) bits = {2'b0, INF_BITS};
      if (spec3_ff) begin
         res_in = sval3_ff;
      end else if (zero3_ff) begin
         res_in = {sign3_ff, 15'd0};
      end else begin
         res_in = {sign3_ff, bits[14:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire

// ===== hdl/fp6_to_fp16_dequant_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_packed_group[47:0], req_row_scale[15:0]
// rsp       out        rsp_valid/rsp_stall   rsp_value_0 .. rsp_value_7 [15:0]
//
// One beat per cycle in and out unless rsp_stall holds the pipe; each beat passes the
// decode, multiply, leading-one/exponent and round/pack stages in each of eight lanes.
// Reset clears only the stage valid bits.
// Stages hold per stage under rsp_stall; empty stages keep filling, so input
// stalls only once all four stages hold beats.
module fp6_to_fp16_dequant_scale (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [47:0] req_packed_group,
   input  wire  [15:0] req_row_scale,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [15:0] rsp_value_0,
   output logic [15:0] rsp_value_1,
   output logic [15:0] rsp_value_2,
   output logic [15:0] rsp_value_3,
   output logic [15:0] rsp_value_4,
   output logic [15:0] rsp_value_5,
   output logic [15:0] rsp_value_6,
   output logic [15:0] rsp_value_7
);
   import dqs_pkg::*;

   pipe_ctrl_type ctrl;
   logic [15:0]   vals [LANES];

   dqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   for (genvar n = 0; n < LANES; n++) begin : g_lane
      dqs_lane u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .v6     (req_packed_group[GROUP_W-1-FP6_W*n -: FP6_W]),
         .scale  (req_row_scale),
         .result (vals[n])
      );
   end

   assign rsp_value_0 = vals[0];
   assign rsp_value_1 = vals[1];
   assign rsp_value_2 = vals[2];
   assign rsp_value_3 = vals[3];
   assign rsp_value_4 = vals[4];
   assign rsp_value_5 = vals[5];
   assign rsp_value_6 = vals[6];
   assign rsp_value_7 = vals[7];

endmodule
`default_nettype wire
